// ===== hw/rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_POP_REAR   = 2'd1,
        ACT_PUSH_FRONT = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

// ===== hw/rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output bdq_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_accept   = (r_state == S_IDLE) && i_s_tvalid;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_tvalid;
    assign o_cmd.capture = w_accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_LOAD) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/bdq_dpath.sv =====
`timescale 1ns / 1ps

module bdq_dpath #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdq_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_action,
    input  logic [bdq_pkg::WORD_W-1:0]    i_push_value,
    output logic [1:0]                    o_status,
    output logic [bdq_pkg::WORD_W-1:0]    o_popped_value
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned SW = IW + 1;

    logic [bdq_pkg::WORD_W-1:0] r_mem [CAPACITY];

    bdq_pkg::t_action           r_action;
    logic [bdq_pkg::WORD_W-1:0] r_value;
    logic [IW-1:0]              r_head;
    logic [CW-1:0]              r_occ;
    bdq_pkg::t_status           r_status;
    logic                       r_pop_ok;
    logic [bdq_pkg::WORD_W-1:0] r_rd_data;
    logic [bdq_pkg::WORD_W-1:0] r_out_data;
    bdq_pkg::t_status           r_out_status;

    logic          w_full;
    logic          w_empty;
    logic          w_is_push;
    logic          w_ok;
    logic [SW-1:0] w_rear_sum;
    logic [IW-1:0] w_pos;
    logic [IW-1:0] n_head;
    logic [CW-1:0] n_occ;

    function automatic logic [IW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        begin
            t = (s >= SW'(CAPACITY)) ? (s - SW'(CAPACITY)) : s;
            return t[IW-1:0];
        end
    endfunction

    assign w_full     = (r_occ == CW'(CAPACITY));
    assign w_empty    = (r_occ == '0);
    assign w_is_push  = (r_action == bdq_pkg::ACT_PUSH_REAR) ||
                        (r_action == bdq_pkg::ACT_PUSH_FRONT);
    assign w_ok       = w_is_push ? !w_full : !w_empty;
    assign w_rear_sum = SW'(r_head) + SW'(r_occ);

    always_comb begin
        w_pos  = r_head;
        n_head = r_head;
        n_occ  = w_is_push ? (r_occ + CW'(1)) : (r_occ - CW'(1));
        case (r_action)
            bdq_pkg::ACT_PUSH_REAR: begin
                w_pos = f_wrap(w_rear_sum);
            end
            bdq_pkg::ACT_POP_REAR: begin
                w_pos = f_wrap(w_rear_sum - SW'(1));
            end
            bdq_pkg::ACT_PUSH_FRONT: begin
                w_pos  = (r_head == '0) ? IW'(CAPACITY - 1) : (r_head - IW'(1));
                n_head = w_pos;
            end
            default: begin
                w_pos  = r_head;
                n_head = f_wrap(SW'(r_head) + SW'(1));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else if (i_cmd.exec && w_ok) begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= bdq_pkg::t_action'(i_action);
            r_value  <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_pop_ok <= w_ok && !w_is_push;
            if (w_ok) begin
                r_status <= bdq_pkg::ST_DONE;
            end else if (w_is_push) begin
                r_status <= bdq_pkg::ST_FULL;
            end else begin
                r_status <= bdq_pkg::ST_EMPTY;
            end
        end
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_data   <= r_pop_ok ? r_rd_data : '0;
        end
    end

    // ring storage, one port: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_ok && w_is_push) begin
                r_mem[w_pos] <= r_value;
            end
            r_rd_data <= r_mem[w_pos];
        end
    end

    assign o_status       = r_out_status;
    assign o_popped_value = r_out_data;

endmodule

// ===== hw/rtl/bounded_double_ended_queue_core.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of CAPACITY signed 32-bit words held in a ring
// (head index plus occupancy count). Each input word asks for push rear, pop
// rear, push front or pop front (s tuser) and gives exactly one output word:
// a status in m tuser (done, rejected full, rejected empty) and the popped
// word in m tdata (zero unless a pop succeeded). One operation is in work at
// a time: accept, ring update with storage access, then output load; the
// storage has a single port with a registered read, and the output load
// waits until the output side is free. A new operation is accepted while
// the previous result still waits in the output register.
module bounded_double_ended_queue_core #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] push_value
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] popped_value
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    bdq_pkg::t_cmd w_cmd;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    bdq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_action       (i_s_tuser),
        .i_push_value   (i_s_tdata),
        .o_status       (o_m_tuser),
        .o_popped_value (o_m_tdata)
    );

endmodule
